FILE: rtl/core/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared types and constants of the two-level page table walk core: field
// widths, function codes, the queued command and the walk result.
// ----------------------------------------------------------------------------
package tpw_pkg;

  localparam int PAGE_BYTES = 32;
  localparam int OFF_W      = 5;
  localparam int IDX_W      = 5;
  localparam int FRAME_W    = 7;
  localparam int BYTE_W     = 8;
  localparam int LADDR_W    = 12;
  localparam int VA_W       = 15;
  localparam int FUNC_W     = 2;
  localparam int VALID_BIT  = 7;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_MEM  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_DISK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_XLATE     = 2'd2;

  localparam logic [FRAME_W-1:0] DIR_BASE_RESET = 7'd108;

  typedef struct packed {
    logic [FUNC_W-1:0]  kind;
    logic [LADDR_W-1:0] laddr;
    logic [BYTE_W-1:0]  lbyte;
    logic [VA_W-1:0]    va;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]   dir_index;
    logic [BYTE_W-1:0]  dir_entry;
    logic               dir_valid;
    logic [FRAME_W-1:0] dir_frame;
    logic [IDX_W-1:0]   table_index;
    logic [BYTE_W-1:0]  table_entry;
    logic               table_valid;
    logic [FRAME_W-1:0] table_frame;
    logic [LADDR_W-1:0] target_addr;
    logic               from_disk;
    logic [BYTE_W-1:0]  value;
    logic               dir_fault;
  } res_t;

endpackage

FILE: rtl/core/two_level_page_table_walk_core.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walk_core
// Two-level page table walk over a byte memory and a disk store.
// Translation: directory, table and data reads in turn on the read address
//   shared by memory and disk; no new command until the result is registered.
// Directory fault: one per cycle if the output is free. Loads: one per cycle when idle.
// Reset: directory base 108, queue and output emptied; stores keep contents.
// ----------------------------------------------------------------------------
module two_level_page_table_walk_core #(
  parameter int NUM_PAGES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // page_dir_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // load_addr[11:0], load_byte[19:12], virt_addr[34:20]
  input  logic [1:0]  in_tuser,      // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // dir_index[4:0], dir_entry[12:5], dir_valid[13],
                                     // dir_frame[20:14], table_index[25:21],
                                     // table_entry[33:26], table_valid[34],
                                     // table_frame[41:35], target_addr[53:42],
                                     // from_disk[54], value[62:55]
  output logic [0:0]  out_tuser      // dir_fault[0]
);

  logic [tpw_pkg::FRAME_W-1:0] dir_base_r;
  logic                        q_valid;
  tpw_pkg::cmd_t               q_cmd;
  logic                        q_pop;
  tpw_pkg::res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= tpw_pkg::DIR_BASE_RESET;
    end else if (cfg_wr_en) begin
      dir_base_r <= cfg_wr_data;
    end
  end

  tpw_front #(.NUM_PAGES(NUM_PAGES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_func      (in_tuser),
    .in_load_addr (in_tdata[11:0]),
    .in_load_byte (in_tdata[19:12]),
    .in_virt_addr (in_tdata[34:20]),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  tpw_back #(.NUM_PAGES(NUM_PAGES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dir_base   (dir_base_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {1'b0, res.value, res.from_disk, res.target_addr, res.table_frame,
                      res.table_valid, res.table_entry, res.table_index, res.dir_frame,
                      res.dir_valid, res.dir_entry, res.dir_index};
  assign out_tuser = res.dir_fault;

  a_fault_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[62:26] == '0)
    else $error("fault result carries table or data fields");

  a_fault_matches_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13] != out_tuser[0])
    else $error("dir_valid and dir_fault disagree");

  a_target_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[53:47] == out_tdata[41:35] && out_tdata[54] != out_tdata[34])
    else $error("target address or source inconsistent with table entry");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

endmodule

FILE: rtl/core/tpw_ram.sv
// ----------------------------------------------------------------------------
// tpw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/tpw_front.sv
// ----------------------------------------------------------------------------
// tpw_front
// Input side: accept words, drop unused function codes and loads beyond the
// last page, queue the remaining commands for the walk engine.
// ----------------------------------------------------------------------------
module tpw_front #(
  parameter int NUM_PAGES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tpw_pkg::FUNC_W-1:0]       in_func,
  input  logic [tpw_pkg::LADDR_W-1:0]      in_load_addr,
  input  logic [tpw_pkg::BYTE_W-1:0]       in_load_byte,
  input  logic [tpw_pkg::VA_W-1:0]         in_virt_addr,
  output logic                             q_valid,
  output tpw_pkg::cmd_t                    q_cmd,
  input  logic                             q_pop
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  tpw_pkg::cmd_t     entry_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              keep;
  logic              push;
  logic              pop;
  logic [tpw_pkg::FRAME_W-1:0] load_page;

  assign load_page = in_load_addr[tpw_pkg::LADDR_W-1:tpw_pkg::OFF_W];

  always_comb begin
    unique case (in_func)
      tpw_pkg::FUNC_LOAD_MEM,
      tpw_pkg::FUNC_LOAD_DISK: keep = ({1'b0, load_page} < 8'(NUM_PAGES));
      tpw_pkg::FUNC_XLATE:     keep = 1'b1;
      default:                 keep = 1'b0;
    endcase
  end

  assign in_tready = rst_n && (cnt_r != CNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{kind:  in_func,
                             laddr: in_load_addr,
                             lbyte: in_load_byte,
                             va:    in_virt_addr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/tpw_back.sv
// ----------------------------------------------------------------------------
// tpw_back
// Walk engine: carries out queued loads and translations over the memory and
// disk stores, up to three dependent reads per walk, into an output register.
// ----------------------------------------------------------------------------
module tpw_back #(
  parameter int NUM_PAGES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tpw_pkg::FRAME_W-1:0]      dir_base,
  input  logic                             q_valid,
  input  tpw_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output tpw_pkg::res_t                    out_res
);

  localparam int PW    = $clog2(NUM_PAGES);
  localparam int AW    = PW + tpw_pkg::OFF_W;
  localparam int DEPTH = NUM_PAGES * tpw_pkg::PAGE_BYTES;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIR  = 3'd1;
  localparam logic [2:0] S_TBL  = 3'd2;
  localparam logic [2:0] S_DAT  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  tpw_pkg::res_t                 res_r, res_nxt;
  tpw_pkg::res_t                 fin;
  logic [tpw_pkg::OFF_W-1:0]     off_r, off_nxt;
  logic                          oor_r, oor_nxt;
  logic                          src_disk_r, src_disk_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tpw_pkg::res_t                 out_res_r, out_res_nxt;

  logic                          out_free;
  logic                          finish;
  logic                          can_start;
  logic [tpw_pkg::FRAME_W-1:0]   rd_page;
  logic [tpw_pkg::OFF_W-1:0]     rd_off;
  logic                          rd_disk;
  logic [tpw_pkg::BYTE_W-1:0]    rd_byte;
  logic [tpw_pkg::BYTE_W-1:0]    mem_rdata;
  logic [tpw_pkg::BYTE_W-1:0]    disk_rdata;
  logic                          mem_we;
  logic                          disk_we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;

  assign out_free = !out_valid_r || out_tready;
  assign rd_byte  = oor_r ? '0 : (src_disk_r ? disk_rdata : mem_rdata);
  assign waddr    = {q_cmd.laddr[tpw_pkg::OFF_W +: PW], q_cmd.laddr[tpw_pkg::OFF_W-1:0]};
  assign raddr    = {rd_page[PW-1:0], rd_off};

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    fin           = res_r;
    finish        = 1'b0;
    rd_page       = '0;
    rd_off        = '0;
    rd_disk       = 1'b0;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    disk_we       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
      end
      S_DIR: begin
        fin.dir_entry = rd_byte;
        fin.dir_valid = rd_byte[tpw_pkg::VALID_BIT];
        fin.dir_frame = rd_byte[tpw_pkg::FRAME_W-1:0];
        if (rd_byte[tpw_pkg::VALID_BIT]) begin
          res_nxt   = fin;
          rd_page   = rd_byte[tpw_pkg::FRAME_W-1:0];
          rd_off    = res_r.table_index;
          state_nxt = S_TBL;
        end else begin
          fin.dir_fault = 1'b1;
          finish        = 1'b1;
        end
      end
      S_TBL: begin
        fin.table_entry = rd_byte;
        fin.table_valid = rd_byte[tpw_pkg::VALID_BIT];
        fin.table_frame = rd_byte[tpw_pkg::FRAME_W-1:0];
        fin.target_addr = {rd_byte[tpw_pkg::FRAME_W-1:0], off_r};
        fin.from_disk   = !rd_byte[tpw_pkg::VALID_BIT];
        res_nxt         = fin;
        rd_page         = rd_byte[tpw_pkg::FRAME_W-1:0];
        rd_off          = off_r;
        rd_disk         = !rd_byte[tpw_pkg::VALID_BIT];
        state_nxt       = S_DAT;
      end
      S_DAT: begin
        fin.value = rd_byte;
        finish    = 1'b1;
      end
      S_HOLD: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = fin;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = fin;
        state_nxt = S_HOLD;
      end
    end

    can_start = (state_r == S_IDLE) || (finish && out_free);

    if (can_start && q_valid) begin
      q_pop = 1'b1;
      unique case (q_cmd.kind)
        tpw_pkg::FUNC_LOAD_MEM: begin
          mem_we = 1'b1;
        end
        tpw_pkg::FUNC_LOAD_DISK: begin
          disk_we = 1'b1;
        end
        tpw_pkg::FUNC_XLATE: begin
          res_nxt             = '0;
          res_nxt.dir_index   = q_cmd.va[tpw_pkg::VA_W-1 -: tpw_pkg::IDX_W];
          res_nxt.table_index = q_cmd.va[tpw_pkg::OFF_W +: tpw_pkg::IDX_W];
          off_nxt             = q_cmd.va[tpw_pkg::OFF_W-1:0];
          rd_page             = dir_base;
          rd_off              = q_cmd.va[tpw_pkg::VA_W-1 -: tpw_pkg::IDX_W];
          state_nxt           = S_DIR;
        end
        default: begin
        end
      endcase
    end

    oor_nxt      = !({1'b0, rd_page} < 8'(NUM_PAGES));
    src_disk_nxt = rd_disk;
  end

  tpw_ram #(.WIDTH(tpw_pkg::BYTE_W), .DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (q_cmd.lbyte),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  tpw_ram #(.WIDTH(tpw_pkg::BYTE_W), .DEPTH(DEPTH)) u_disk (
    .clk   (clk),
    .we    (disk_we),
    .waddr (waddr),
    .wdata (q_cmd.lbyte),
    .raddr (raddr),
    .rdata (disk_rdata)
  );

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    off_r      <= off_nxt;
    oor_r      <= oor_nxt;
    src_disk_r <= src_disk_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule
